// File: rtl/core/dst_pkg.sv
// shared types, constants and helpers for the descriptor slot table
// no dependencies; used by dst_store and descriptor_slot_table_top
package dst_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int DESC_BASE  = 2;
   localparam int HANDLE_W   = 32;
   localparam int DESC_W     = 8;
   localparam int ACTION_W   = 2;

   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [SLOT_COUNT-1:0] occ_type;

   // one item handed from the channel logic to the store
   typedef struct packed {
      logic                en;
      logic [ACTION_W-1:0] action;
      logic [HANDLE_W-1:0] handle;
      logic [DESC_W-1:0]   descriptor;
   } dst_op_type;

   // result fields of the item last handed to the store
   typedef struct packed {
      logic                status;
      logic [DESC_W-1:0]   assigned_descriptor;
      logic [HANDLE_W-1:0] found_handle;
   } dst_res_type;

   // lowest clear bit of the occupancy vector
   function automatic slot_type lowest_free(input occ_type occ);
      slot_type idx;
      idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!occ[i]) begin
            idx = slot_type'(i);
         end
      end
      return idx;
   endfunction

endpackage

// File: rtl/core/descriptor_slot_table_top.sv
// descriptor slot table: stream channels, result register, slot store
// depends on dst_pkg and dst_store
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tuser action, tdata handle + descriptor
//  rsp      out  rsp_tvalid/rsp_tready  tuser status, tdata descriptor + handle
//
// one item per cycle while results are taken; an accepted item goes through the
// store stage, which updates occupancy flags and issues the memory read or write,
// then the result register, which registers the result and raises rsp_tvalid
// reset clears every occupancy flag at once; no clearing pass over the memory
// a stalled result holds; req_tready drops only while both stages are full
module descriptor_slot_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] action
   input  logic [39:0] req_tdata,   // [31:0] handle, [39:32] descriptor
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [0:0]  rsp_tuser,   // [0] status
   output logic [39:0] rsp_tdata    // [7:0] assigned_descriptor, [39:8] found_handle
);

   dst_pkg::dst_op_type  op;
   dst_pkg::dst_res_type res;

   logic        s1_valid_ff, s1_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_status_ff;
   logic [39:0] rsp_data_ff;
   logic        rsp_free;
   logic        s1_adv;
   logic        req_acc;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      op.en         = req_acc;
      op.action     = req_tuser;
      op.handle     = req_tdata[31:0];
      op.descriptor = req_tdata[39:32];
   end

   dst_store u_store (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .res   (res)
   );

   always_comb begin
      s1_valid_in  = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_status_ff <= res.status;
         rsp_data_ff   <= {res.found_handle, res.assigned_descriptor};
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_status_ff;
   assign rsp_tdata    = rsp_data_ff;

`ifndef SYNTHESIS
   a_acc_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> s1_valid_ff)
      else $error("accepted item lost before the result stage");

   a_stalled_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_free) |=> s1_valid_ff)
      else $error("pending item dropped under stall");

   a_ok_add_desc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_status_ff && rsp_data_ff[7:0] != 8'd0)
      |-> (rsp_data_ff[7:0] >= 8'(dst_pkg::DESC_BASE)))
      else $error("assigned descriptor below the base");
`endif

endmodule

// File: rtl/core/dst_store.sv
// handle memory with per-slot occupancy flags; serves add, look up, remove
// depends on dst_pkg
module dst_store (
   input  logic                clock,
   input  logic                reset,
   input  dst_pkg::dst_op_type op,
   output dst_pkg::dst_res_type res
);

   logic [dst_pkg::HANDLE_W-1:0] mem [dst_pkg::SLOT_COUNT];

   dst_pkg::occ_type  occ_ff, occ_in;
   logic [dst_pkg::HANDLE_W-1:0] rdata_ff;

   logic                       status_ff, status_in;
   logic [dst_pkg::DESC_W-1:0] assigned_ff, assigned_in;
   logic                       lookup_ff, lookup_in;
   logic                       hit_ff, hit_in;

   logic [dst_pkg::DESC_W-1:0] desc_off;
   logic                       in_range;
   dst_pkg::slot_type          desc_slot;
   dst_pkg::slot_type          free_slot;
   logic                       full;
   logic                       wr_en;
   logic                       rd_en;

   assign desc_off  = op.descriptor - dst_pkg::DESC_W'(dst_pkg::DESC_BASE);
   assign in_range  = (op.descriptor >= dst_pkg::DESC_W'(dst_pkg::DESC_BASE)) &&
                      (desc_off < dst_pkg::DESC_W'(dst_pkg::SLOT_COUNT));
   assign desc_slot = desc_off[dst_pkg::SLOT_W-1:0];
   assign free_slot = dst_pkg::lowest_free(occ_ff);
   assign full      = &occ_ff;

   always_comb begin
      occ_in      = occ_ff;
      status_in   = 1'b1;
      assigned_in = '0;
      lookup_in   = 1'b0;
      hit_in      = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      unique case (op.action)
         dst_pkg::ACT_ADD: begin
            if (op.handle != '0 && !full) begin
               wr_en             = op.en;
               occ_in[free_slot] = 1'b1;
               status_in         = 1'b0;
               assigned_in       = dst_pkg::DESC_W'(free_slot) +
                                   dst_pkg::DESC_W'(dst_pkg::DESC_BASE);
            end
         end
         dst_pkg::ACT_LOOKUP: begin
            lookup_in = 1'b1;
            if (in_range) begin
               rd_en     = op.en;
               hit_in    = occ_ff[desc_slot];
               status_in = 1'b0;
            end
         end
         dst_pkg::ACT_REMOVE: begin
            if (in_range) begin
               occ_in[desc_slot] = 1'b0;
               status_in         = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (op.en) begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op.en) begin
         status_ff   <= status_in;
         assigned_ff <= assigned_in;
         lookup_ff   <= lookup_in;
         hit_ff      <= hit_in;
      end
   end

   // stale data of empty slots may be read but is never returned: the occupancy flag masks it
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[free_slot] <= op.handle;
      end
      if (rd_en) begin
         rdata_ff <= mem[desc_slot];
      end
   end

   always_comb begin
      res.status              = status_ff;
      res.assigned_descriptor = assigned_ff;
      res.found_handle        = (lookup_ff && hit_ff) ? rdata_ff : '0;
   end

`ifndef SYNTHESIS
   a_add_sets_occ: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> occ_ff[$past(free_slot)])
      else $error("add did not mark its slot occupied");

   a_remove_clears_occ: assert property (@(posedge clock) disable iff (reset)
      (op.en && op.action == dst_pkg::ACT_REMOVE && in_range)
      |=> !occ_ff[$past(desc_slot)])
      else $error("remove left its slot occupied");

   a_full_no_write: assert property (@(posedge clock) disable iff (reset)
      full |-> !wr_en)
      else $error("write into a full table");

   a_fail_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (res.status == 1'b1) |-> (res.assigned_descriptor == '0 && res.found_handle == '0))
      else $error("failed item carries nonzero result fields");
`endif

endmodule

// File: tb/tb.sv
// testbench for descriptor_slot_table_top: directed and random add, look up and remove items
// checked against a shadow copy of the slot table; depends on dst_pkg and the rtl top
module tb;

   localparam logic [dst_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 80;
   localparam int LAST_DESC    = dst_pkg::DESC_BASE + dst_pkg::SLOT_COUNT - 1;

   typedef struct {
      logic                         status;
      logic [dst_pkg::DESC_W-1:0]   assigned;
      logic [dst_pkg::HANDLE_W-1:0] found;
   } slot_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // [1:0] action
   logic [39:0] req_tdata;   // [31:0] handle, [39:32] descriptor
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [0:0]  rsp_tuser;   // [0] status
   logic [39:0] rsp_tdata;   // [7:0] assigned_descriptor, [39:8] found_handle

   logic [dst_pkg::HANDLE_W-1:0] shadow_slots [dst_pkg::SLOT_COUNT];
   slot_result_type              pending_responses [$];

   int  error_count;
   int  cycle_count;
   int  checked_count;
   int  add_count;
   int  lookup_count;
   int  remove_count;
   int  unused_count;
   int  full_rejects;
   int  fail_results;
   bit  req_idle_on;
   bit  rsp_stall_on;
   int  rsp_hold_cycles;

   descriptor_slot_table_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // updates the shadow table and returns the result the block owes for this item
   function automatic slot_result_type serve_request(
      input logic [dst_pkg::ACTION_W-1:0] action,
      input logic [dst_pkg::HANDLE_W-1:0] handle,
      input logic [dst_pkg::DESC_W-1:0]   desc);
      slot_result_type res;
      bit              in_range;
      bit              placed;
      int              slot;
      int              i;
      res.status   = 1'b1;
      res.assigned = '0;
      res.found    = '0;
      placed       = 1'b0;
      in_range     = (int'(desc) >= dst_pkg::DESC_BASE) &&
                     (int'(desc) - dst_pkg::DESC_BASE < dst_pkg::SLOT_COUNT);
      slot         = int'(desc) - dst_pkg::DESC_BASE;
      case (action)
         dst_pkg::ACT_ADD: begin
            if (handle != '0) begin
               for (i = 0; i < dst_pkg::SLOT_COUNT; i++) begin
                  if (!placed && shadow_slots[i] == '0) begin
                     shadow_slots[i] = handle;
                     res.assigned    = dst_pkg::DESC_W'(i + dst_pkg::DESC_BASE);
                     res.status      = 1'b0;
                     placed          = 1'b1;
                  end
               end
               if (!placed) full_rejects++;
            end
         end
         dst_pkg::ACT_LOOKUP: begin
            if (in_range) begin
               res.found  = shadow_slots[slot];
               res.status = 1'b0;
            end
         end
         dst_pkg::ACT_REMOVE: begin
            if (in_range) begin
               shadow_slots[slot] = '0;
               res.status         = 1'b0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // every accepted item gets its expected result queued here
   always @(posedge clock) begin : request_monitor
      if (!reset && req_tvalid === 1'b1 && req_tready === 1'b1) begin
         case (req_tuser)
            dst_pkg::ACT_ADD:    add_count++;
            dst_pkg::ACT_LOOKUP: lookup_count++;
            dst_pkg::ACT_REMOVE: remove_count++;
            default:             unused_count++;
         endcase
         pending_responses.push_back(serve_request(req_tuser, req_tdata[31:0],
                                                   req_tdata[39:32]));
      end
   end

   always @(posedge clock) begin : response_checker
      slot_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_responses.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending, tdata %h", rsp_tdata));
         end else begin
            want = pending_responses.pop_front();
            checked_count++;
            if (rsp_tuser[0] === 1'b1) fail_results++;
            if (rsp_tuser[0] !== want.status)
               report_mismatch($sformatf("status %b, want %b", rsp_tuser[0], want.status));
            if (rsp_tdata[7:0] !== want.assigned)
               report_mismatch($sformatf("assigned_descriptor %0d, want %0d",
                                         rsp_tdata[7:0], want.assigned));
            if (rsp_tdata[39:8] !== want.found)
               report_mismatch($sformatf("found_handle %h, want %h",
                                         rsp_tdata[39:8], want.found));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_responses.size());
         $display("FAIL descriptor_slot_table_top");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold when one is requested
   initial begin : response_taker
      int wait_cycles;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         wait_cycles = rsp_stall_on ? $urandom_range(0, 5) : 0;
         wait_cycles += rsp_hold_cycles;
         rsp_hold_cycles = 0;
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready === 1'b1));
      end
   end

   // returns right after the edge at which the item was taken
   task automatic send_request(input logic [dst_pkg::ACTION_W-1:0] action,
                               input logic [dst_pkg::HANDLE_W-1:0] handle,
                               input logic [dst_pkg::DESC_W-1:0]   desc);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {desc, handle};
      do @(posedge clock); while (!(req_tvalid === 1'b1 && req_tready === 1'b1));
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_corner_requests();
      send_request(dst_pkg::ACT_ADD, 32'h0, 8'd2);               // null handle
      send_request(dst_pkg::ACT_LOOKUP, 32'h0,
                   dst_pkg::DESC_W'(dst_pkg::DESC_BASE));        // empty slot in range
      send_request(dst_pkg::ACT_REMOVE, 32'h0,
                   dst_pkg::DESC_W'(LAST_DESC));                 // empty last slot
      send_request(ACT_UNUSED, 32'hFFFF_FFFF, 8'hFF);
      send_request(dst_pkg::ACT_LOOKUP, 32'h0, 8'd0);
      send_request(dst_pkg::ACT_LOOKUP, 32'h0, 8'd1);
      send_request(dst_pkg::ACT_REMOVE, 32'h0, dst_pkg::DESC_W'(LAST_DESC + 1));
      send_request(dst_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 8'hFF);
      wait_for_drain();
   endtask

   task automatic test_fill_table();
      int i;
      send_request(dst_pkg::ACT_ADD, 32'hFFFF_FFFF, 8'h0);
      send_request(dst_pkg::ACT_ADD, 32'h0000_0001, 8'hFF);
      send_request(dst_pkg::ACT_ADD, 32'h8000_0000, 8'h0);
      for (i = 3; i < dst_pkg::SLOT_COUNT; i++) begin
         send_request(dst_pkg::ACT_ADD, $urandom | 32'h1, 8'($urandom_range(0, 255)));
      end
      send_request(dst_pkg::ACT_ADD, 32'h1234_5678, 8'h0);       // table full
      wait_for_drain();
   endtask

   task automatic issue_random_request(input int add_weight);
      int                           pick;
      logic [dst_pkg::HANDLE_W-1:0] handle;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0:       handle = 32'hFFFF_FFFF;
         1:       handle = 32'h0000_0001;
         default: handle = $urandom;
      endcase
      if (pick < add_weight) begin
         send_request(dst_pkg::ACT_ADD, handle, 8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
         send_request(($urandom_range(0, 1) == 0) ? dst_pkg::ACT_LOOKUP : dst_pkg::ACT_REMOVE,
                      handle, 8'($urandom_range(dst_pkg::DESC_BASE, LAST_DESC)));
      end else if (pick < 96) begin
         send_request(($urandom_range(0, 1) == 0) ? dst_pkg::ACT_LOOKUP : dst_pkg::ACT_REMOVE,
                      handle, 8'($urandom_range(0, 255)));
      end else if (pick < 98) begin
         send_request(dst_pkg::ACT_ADD, 32'h0, 8'($urandom_range(0, 255)));
      end else begin
         send_request(ACT_UNUSED, handle, 8'($urandom_range(0, 255)));
      end
   endtask

   // idling on either side is switched in stretches
   task automatic test_random_traffic(input int count, input int add_weight);
      int n;
      for (n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            req_idle_on  = 1'($urandom_range(0, 1));
            rsp_stall_on = 1'($urandom_range(0, 1));
         end
         issue_random_request(add_weight);
      end
      wait_for_drain();
   endtask

   task automatic test_back_to_back(input int count);
      int n;
      req_idle_on  = 1'b0;
      rsp_stall_on = 1'b0;
      for (n = 0; n < count; n++) issue_random_request(45);
      wait_for_drain();
   endtask

   // result side holds off while items keep coming, so req_tready must drop
   task automatic test_output_backpressure(input int count);
      int n;
      req_idle_on     = 1'b0;
      rsp_stall_on    = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      for (n = 0; n < count; n++) issue_random_request(50);
      wait_for_drain();
   endtask

   task automatic finish_run();
      if (pending_responses.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_responses.size()));
      $display("checked %0d results: %0d adds (%0d on a full table), %0d look ups, %0d removes,",
               checked_count, add_count, full_rejects, lookup_count, remove_count);
      $display("%0d unused codes, %0d failure results, one %0d-cycle output hold",
               unused_count, fail_results, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("PASS descriptor_slot_table_top");
      end else begin
         $display("FAIL descriptor_slot_table_top");
      end
      $finish;
   endtask

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tuser       = '0;
      req_tdata       = '0;
      rsp_tready      = 1'b0;
      req_idle_on     = 1'b1;
      rsp_stall_on    = 1'b1;
      rsp_hold_cycles = 0;
      for (int i = 0; i < dst_pkg::SLOT_COUNT; i++) shadow_slots[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_requests();
      test_fill_table();
      test_random_traffic(300, 55);
      test_back_to_back(200);
      test_output_backpressure(30);
      test_random_traffic(400, 20);
      finish_run();
   end

endmodule

// File: sim.f
rtl/core/dst_pkg.sv
rtl/core/dst_store.sv
rtl/core/descriptor_slot_table_top.sv
tb/tb.sv
